// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/dqb_pkg.sv =====
package dqb_pkg;

  localparam int LabelMax = 58;
  localparam int CountW   = 6;
  localparam int AddrW    = $clog2(LabelMax);
  localparam int CfgW     = 16;
  localparam int CfgAddrW = 2;

  localparam logic [7:0] DotChar = 8'h2e;

  // register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] CfgQueryId    = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgRecursion  = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgQueryType  = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgQueryClass = 2'd3;

  // one output byte as planned by the sequencer
  typedef struct packed {
    logic [7:0] data;
    logic       from_ram;
    logic       run_end;
    logic       msg_end;
    logic       ovf;
  } desc_t;

  // label ram access from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/dqb_ram.sv =====
module dqb_ram #(
  parameter int Width = 8,
  parameter int Depth = 58
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dqb_ctrl.sv =====
`include "assert_macros.svh"

module dqb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dqb_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [dqb_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_char_i,
  input  logic                          in_final_i,
  output logic                          desc_valid_o,
  output dqb_pkg::desc_t                desc_o,
  input  logic                          desc_ready_i,
  output dqb_pkg::ram_req_t             ram_req_o
);
  import dqb_pkg::*;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhHdr  = 3'd1;
  localparam logic [2:0] PhLen  = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhTail = 3'd4;

  localparam logic [CountW-1:0] HdrLast  = CountW'(11);
  localparam logic [CountW-1:0] TailLast = CountW'(4);
  localparam logic [CountW-1:0] CntMax   = CountW'(LabelMax);

  // configuration registers
  logic [15:0] id_q, type_q, class_q;
  logic        rd_q;

  // message state
  logic              at_start_q;
  logic [CountW-1:0] count_q;
  logic              ovf_q;

  // byte sequencer
  logic [2:0]        phase_q;
  logic [CountW-1:0] idx_q;
  logic              flush_q, tail_q, item_ovf_q;
  logic [CountW-1:0] cnt_q;

  logic              accept, step, is_dot, store, ovf_new, flush_new;
  logic [CountW-1:0] cnt_new;
  logic [2:0]        start_phase, nxt_phase;
  logic              last_of_phase;

  assign in_ready_o = (phase_q == PhIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign is_dot    = (in_char_i == DotChar);
  assign store     = !is_dot && (count_q < CntMax);
  assign cnt_new   = store ? count_q + CountW'(1) : count_q;
  assign ovf_new   = ovf_q || (!is_dot && !store);
  assign flush_new = in_final_i ? (!is_dot || (cnt_new != '0)) : is_dot;

  always_comb begin
    if (at_start_q) begin
      start_phase = PhHdr;
    end else if (flush_new) begin
      start_phase = PhLen;
    end else if (in_final_i) begin
      start_phase = PhTail;
    end else begin
      start_phase = PhIdle;
    end
  end

  assign desc_valid_o = (phase_q != PhIdle);
  assign step         = desc_valid_o && desc_ready_i;

  always_comb begin
    desc_o          = '0;
    desc_o.ovf      = item_ovf_q;
    last_of_phase   = 1'b0;
    nxt_phase       = PhIdle;
    case (phase_q)
      PhHdr: begin
        case (idx_q)
          CountW'(0): desc_o.data = id_q[15:8];
          CountW'(1): desc_o.data = id_q[7:0];
          CountW'(2): desc_o.data = {7'd0, rd_q};
          CountW'(5): desc_o.data = 8'd1;
          default:    desc_o.data = 8'd0;
        endcase
        last_of_phase = (idx_q == HdrLast);
        nxt_phase     = flush_q ? PhLen : (tail_q ? PhTail : PhIdle);
      end
      PhLen: begin
        desc_o.data   = 8'(cnt_q);
        last_of_phase = 1'b1;
        nxt_phase     = (cnt_q != '0) ? PhData : (tail_q ? PhTail : PhIdle);
      end
      PhData: begin
        desc_o.from_ram = 1'b1;
        last_of_phase   = (idx_q == cnt_q - CountW'(1));
        nxt_phase       = tail_q ? PhTail : PhIdle;
      end
      PhTail: begin
        case (idx_q)
          CountW'(1): desc_o.data = type_q[15:8];
          CountW'(2): desc_o.data = type_q[7:0];
          CountW'(3): desc_o.data = class_q[15:8];
          CountW'(4): desc_o.data = class_q[7:0];
          default:    desc_o.data = 8'd0;
        endcase
        last_of_phase  = (idx_q == TailLast);
        nxt_phase      = PhIdle;
        desc_o.msg_end = (idx_q == TailLast);
      end
      default: begin
        nxt_phase = PhIdle;
      end
    endcase
    desc_o.run_end = last_of_phase && (nxt_phase == PhIdle);
  end

  // label store access: one write per kept character, one read per flushed label byte
  always_comb begin
    ram_req_o       = '0;
    ram_req_o.we    = accept && store;
    ram_req_o.waddr = count_q[AddrW-1:0];
    ram_req_o.wdata = in_char_i;
    ram_req_o.re    = step && (phase_q == PhData);
    ram_req_o.raddr = idx_q[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q    <= 16'd0;
      rd_q    <= 1'b1;
      type_q  <= 16'd1;
      class_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgQueryId:    id_q    <= cfg_wdata_i;
        CfgRecursion:  rd_q    <= cfg_wdata_i[0];
        CfgQueryType:  type_q  <= cfg_wdata_i;
        CfgQueryClass: class_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      count_q    <= '0;
      ovf_q      <= 1'b0;
    end else if (accept) begin
      at_start_q <= in_final_i;
      count_q    <= (in_final_i || is_dot) ? '0 : cnt_new;
      ovf_q      <= in_final_i ? 1'b0 : ovf_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      idx_q   <= '0;
    end else if (accept) begin
      phase_q <= start_phase;
      idx_q   <= '0;
    end else if (step) begin
      if (last_of_phase) begin
        phase_q <= nxt_phase;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flush_q    <= flush_new;
      tail_q     <= in_final_i;
      cnt_q      <= cnt_new;
      item_ovf_q <= ovf_new;
    end
  end

  `ASSERT_NEVER(ram_rd_in_range, ram_req_o.re && (ram_req_o.raddr >= AddrW'(LabelMax)), "label read past store")
  `ASSERT_CLK(msg_end_closes_run, (desc_valid_o && desc_o.msg_end) |-> desc_o.run_end, "message end without run end")
  `ASSERT_CLK(hdr_first, (accept && at_start_q) |=> (phase_q == PhHdr), "header not first")

endmodule

// ===== hw/rtl/dqb_out.sv =====
`include "assert_macros.svh"

module dqb_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           desc_valid_i,
  input  dqb_pkg::desc_t desc_i,
  output logic           desc_ready_o,
  input  logic [7:0]     ram_rdata_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_run_end_o,
  output logic           out_msg_end_o,
  output logic           out_ovf_o
);
  import dqb_pkg::*;

  // s1 waits for the ram read data, out is the bus register
  logic  s1_valid_q, out_valid_q;
  desc_t s1_q;
  logic [7:0] out_byte_q;
  logic  out_run_end_q, out_msg_end_q, out_ovf_q;
  logic  s1_move, s1_load;

  assign s1_move      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign desc_ready_o = !s1_valid_q || s1_move;
  assign s1_load      = desc_valid_i && desc_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= desc_i;
    end
    if (s1_move) begin
      out_byte_q    <= s1_q.from_ram ? ram_rdata_i : s1_q.data;
      out_run_end_q <= s1_q.run_end;
      out_msg_end_q <= s1_q.msg_end;
      out_ovf_q     <= s1_q.ovf;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_run_end_o = out_run_end_q;
  assign out_msg_end_o = out_msg_end_q;
  assign out_ovf_o     = out_ovf_q;

  `ASSERT_CLK(s1_filled, s1_load |=> s1_valid_q, "planned byte lost")

endmodule

// ===== hw/rtl/dns_query_builder.sv =====
// channel   | dir | beat contents
// s_axis    | in  | tdata[7:0] name_char, tlast final_char
// m_axis    | out | tdata[7:0] out_byte, tlast run_end, tuser[0] message_end,
//           |     | tuser[1] label_overflow
// cfg       | in  | cfg_we_i, cfg_addr_i register index, cfg_wdata_i value
//
// an input character is accepted, then the bytes it causes (0 to 64 bytes) are planned
// one after another, as set by the single byte sequencer and the one read port
// of the label ram; the next character is taken once the last byte is planned
// two register stages (ram read, bus register) follow the sequencer, so
// stalls on m_axis back up into the sequencer without losing bytes
// reset is asynchronous and active low; the label ram needs no clearing pass

module dns_query_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [dqb_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [dqb_pkg::CfgW-1:0]     cfg_wdata_i,
  // name characters
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] name_char
  input  logic                         s_axis_tlast,
  // query message bytes
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] out_byte
  output logic                         m_axis_tlast,
  output logic [1:0]                   m_axis_tuser   // [0] message_end, [1] label_overflow
);
  import dqb_pkg::*;

  logic     desc_valid, desc_ready;
  desc_t    desc;
  ram_req_t ram_req;
  logic [7:0] ram_rdata;
  logic     msg_end, ovf;

  // sequencer, message state and configuration registers
  dqb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata),
    .in_final_i   (s_axis_tlast),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_ready_i (desc_ready),
    .ram_req_o    (ram_req)
  );

  // label characters, written on accept, read back on flush
  dqb_ram #(
    .Width (8),
    .Depth (LabelMax)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // ram data merge and bus output register
  dqb_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_valid_i  (desc_valid),
    .desc_i        (desc),
    .desc_ready_o  (desc_ready),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_run_end_o (m_axis_tlast),
    .out_msg_end_o (msg_end),
    .out_ovf_o     (ovf)
  );

  assign m_axis_tuser = {ovf, msg_end};

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dqb_pkg::*;

  // quiet cycles (nothing accepted on either side) before the run is called hung
  localparam int QuietLimit   = 3000;
  // cycles allowed after the last byte for the sequencer and both stages to settle
  localparam int SettleCycles = 16;
  // random characters per phase of the random test
  localparam int PhaseChars   = 40;
  // long receiver hold-off used to back the block up into its input
  localparam int HoldCycles   = 400;

  // one message byte as seen on m_axis
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       msg_end;
    logic       ovf;
  } qbyte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] name_char
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // [7:0] out_byte
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;   // [0] message_end, [1] label_overflow

  // bytes the block still owes us, oldest first
  qbyte_t query_bytes_q[$];
  int     err_count   = 0;
  int     chars_sent  = 0;   // accepted characters that were not silently dropped

  // idling knobs of the sender (tx_idle_on) and the receiver (rx_idle_on, rx_hold)
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold    = 0;

  // shadow of the configuration registers, reset values
  logic [15:0] cfg_id    = 16'h0000;
  logic        cfg_rd    = 1'b1;
  logic [15:0] cfg_type  = 16'h0001;
  logic [15:0] cfg_class = 16'h0001;

  // shadow of the builder state
  bit         pr_at_start  = 1'b1;
  int         pr_label_len = 0;
  logic [7:0] pr_label [LabelMax];
  bit         pr_ovf       = 1'b0;

  dns_query_builder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // expected message bytes
  // ---------------------------------------------------------------------------

  // every byte carries the overflow flag as it stands when the byte is planned
  function automatic qbyte_t mk_byte(input logic [7:0] d);
    qbyte_t b;
    b.data    = d;
    b.run_end = 1'b0;
    b.msg_end = 1'b0;
    b.ovf     = pr_ovf;
    return b;
  endfunction

  // length byte, then the held label; the label is consumed
  function automatic void flush_label(ref qbyte_t run[$]);
    run.push_back(mk_byte(8'(pr_label_len)));
    for (int k = 0; k < pr_label_len; k++) run.push_back(mk_byte(pr_label[k]));
    pr_label_len = 0;
  endfunction

  // works out the bytes one accepted character causes and queues them;
  // dropped is set for a character that yields nothing at all
  function automatic void predict_query(input logic [7:0] ch, input logic fin,
                                        output bit dropped);
    qbyte_t run[$];
    bit     is_dot;
    is_dot  = (ch == DotChar);
    dropped = 1'b0;

    // label chars go to the store until it is full, then are dropped
    if (!is_dot) begin
      if (pr_label_len < LabelMax) begin
        pr_label[pr_label_len] = ch;
        pr_label_len++;
      end else begin
        pr_ovf  = 1'b1;
        dropped = !fin;
      end
    end

    // header on the first char of a message: id, rd flags, zero, qdcount 1, zero counts
    if (pr_at_start) begin
      run.push_back(mk_byte(cfg_id[15:8]));
      run.push_back(mk_byte(cfg_id[7:0]));
      run.push_back(mk_byte({7'b0, cfg_rd}));
      run.push_back(mk_byte(8'h00));
      run.push_back(mk_byte(8'h00));
      run.push_back(mk_byte(8'h01));
      for (int k = 0; k < 6; k++) run.push_back(mk_byte(8'h00));
      pr_at_start = 1'b0;
    end

    if (fin) begin
      // a final dot is the root: only a non-empty label is flushed before it
      if (!is_dot || pr_label_len > 0) flush_label(run);
      run.push_back(mk_byte(8'h00));
      run.push_back(mk_byte(cfg_type[15:8]));
      run.push_back(mk_byte(cfg_type[7:0]));
      run.push_back(mk_byte(cfg_class[15:8]));
      run.push_back(mk_byte(cfg_class[7:0]));
      run[run.size()-1].msg_end = 1'b1;
      pr_at_start  = 1'b1;
      pr_label_len = 0;
      pr_ovf       = 1'b0;
    end else if (is_dot) begin
      // inner dot always flushes, an empty label gives a zero length byte
      flush_label(run);
    end

    if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
    foreach (run[i]) query_bytes_q.push_back(run[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] rand_label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == DotChar);
    return c;
  endfunction

  // offers one character beat and waits for it to be taken; valid is only
  // lowered when a gap is inserted, so back-to-back beats keep it high
  task automatic send_char(input logic [7:0] ch, input logic fin);
    int gap;
    bit dropped;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_query(ch, fin, dropped);
    if (!dropped) chars_sent++;
  endtask

  // sends a string, final flag on its last char
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // sender stops offering until every owed byte is back, optionally
  // followed by the settle time the pipeline needs
  task automatic wait_drained(input bit settle);
    s_axis_tvalid <= 1'b0;
    while (query_bytes_q.size() != 0) @(posedge clk_i);
    if (settle) repeat (SettleCycles) @(posedge clk_i);
  endtask

  // writes all four registers back to back, only with the block idle
  task automatic set_config(input logic [15:0] id, input logic rd,
                            input logic [15:0] qt, input logic [15:0] qc);
    logic [CfgW-1:0]     vals [4];
    logic [CfgAddrW-1:0] idx  [4];
    vals = '{id, 16'(rd), qt, qc};
    idx  = '{CfgQueryId, CfgRecursion, CfgQueryType, CfgQueryClass};
    wait_drained(1'b1);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    cfg_id    = id;
    cfg_rd    = rd;
    cfg_type  = qt;
    cfg_class = qc;
  endtask

  // well-formed name: 1 to 4 labels, rare empty or long (50 to 64 char) labels,
  // sometimes closed by a trailing root dot
  task automatic send_random_name();
    int n_lbl;
    int len;
    int sel;
    bit dot_end;
    bit last;
    n_lbl   = $urandom_range(1, 4);
    dot_end = ($urandom_range(0, 3) == 0);
    for (int l = 0; l < n_lbl; l++) begin
      last = (l == n_lbl - 1);
      sel  = $urandom_range(0, 19);
      if (sel == 0) len = 0;
      else if (sel == 1) len = $urandom_range(50, 64);
      else len = $urandom_range(1, 12);
      // the final char has to be a label char when there is no trailing dot
      if (last && !dot_end && len == 0) len = 1;
      for (int k = 0; k < len; k++)
        send_char(rand_label_char(), last && !dot_end && k == len - 1);
      if (!last || dot_end) send_char(DotChar, last);
    end
  endtask

  // broken sequence: random chars with many dots, closed by a final char
  task automatic send_noise();
    int n;
    logic [7:0] c;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 2) == 0) ? DotChar : 8'($urandom_range(0, 255));
      send_char(c, i == n - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // header with reset register values and a one char name
  task automatic test_single_char();
    send_text("a");
  endtask

  // lone root dot, and a name closed by a trailing dot
  task automatic test_root_name();
    send_text(".");
    send_text("a.");
  endtask

  // leading dot, double dot and a final dot right after an empty label
  task automatic test_dot_cases();
    send_text(".x..y");
    send_text("z..");
  endtask

  // char values around the dot and at both ends of the byte
  task automatic test_char_extremes();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h2d, 1'b0);
    send_char(8'h2f, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7f, 1'b0);
    send_char(8'h01, 1'b1);
  endtask

  // register extremes: all ones with rd clear, then all zeros with rd set
  task automatic test_config_extremes();
    set_config(16'hffff, 1'b0, 16'hffff, 16'hffff);
    send_text("q");
    set_config(16'h0000, 1'b1, 16'h0000, 16'h0000);
    send_text("r.");
  endtask

  task automatic test_label_overflow();
    // extra chars dropped, flag stays up through the next label
    for (int i = 0; i < LabelMax + 3; i++) send_char(rand_label_char(), 1'b0);
    send_char(DotChar, 1'b0);
    send_char(8'h62, 1'b1);
    // full label, then a final char that is itself dropped
    for (int i = 0; i < LabelMax; i++) send_char(rand_label_char(), 1'b0);
    send_char(rand_label_char(), 1'b1);
    // exactly full label closed by a root dot, no overflow
    for (int i = 0; i < LabelMax; i++) send_char(rand_label_char(), 1'b0);
    send_char(DotChar, 1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    wait_drained(1'b1);
    // receiver stalls while chars keep coming, so the block backs up
    rx_hold = HoldCycles;
    for (int i = 0; i < 20; i++) send_char(rand_label_char(), 1'b0);
    send_char(DotChar, 1'b0);
    for (int i = 0; i < 40; i++) send_char(rand_label_char(), i == 39);
    // sender pauses until the whole message is back, then resumes
    wait_drained(1'b0);
    send_text("ns.x");
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_names();
    int goal;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_config(16'($urandom), 1'b1, 16'd1, 16'd1);
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b1;
        end
        1: begin
          set_config(16'hffff, 1'b0, 16'hffff, 16'hffff);
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
        2: begin
          set_config(16'h0000, 1'b1, 16'h0000, 16'h0000);
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b0;
        end
        default: begin
          set_config(16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b1;
        end
      endcase
      goal = chars_sent + PhaseChars;
      while (chars_sent < goal) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_random_name();
        if ($urandom_range(0, 11) == 0) wait_drained(1'b0);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus the long hold-off, counted here
  // ---------------------------------------------------------------------------
  initial begin : rx_drive
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall = gap_len();
        m_axis_tready <= (stall == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each output beat against the oldest owed byte
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_check
    qbyte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (query_bytes_q.size() == 0) begin
        $error("unexpected beat: out_byte %02h", m_axis_tdata);
        err_count++;
      end else begin
        want = query_bytes_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tlast !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tlast);
          err_count++;
        end
        if (m_axis_tuser[0] !== want.msg_end) begin
          $error("message_end: expected %0b, got %0b", want.msg_end, m_axis_tuser[0]);
          err_count++;
        end
        if (m_axis_tuser[1] !== want.ovf) begin
          $error("label_overflow: expected %0b, got %0b", want.ovf, m_axis_tuser[1]);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any beat on either side
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CfgQueryId;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_char();
    test_root_name();
    test_dot_cases();
    test_char_extremes();
    test_config_extremes();
    test_label_overflow();
    test_backpressure();
    test_random_names();

    wait_drained(1'b1);
    if (err_count == 0 && query_bytes_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== dns_query_builder.f =====
+incdir+hw/rtl
hw/rtl/dqb_pkg.sv
hw/rtl/dqb_ram.sv
hw/rtl/dqb_ctrl.sv
hw/rtl/dqb_out.sv
hw/rtl/dns_query_builder.sv
sim/tb_top.sv
